/* design/srp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the readahead planner
// Beat layouts of both channels, register codes and page arithmetic.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int unsigned PAGE_BYTES  = 4096;
    localparam int unsigned MIN_W       = 25;
    localparam int unsigned MAX_W       = 29;
    localparam int unsigned REQ_W       = 25;
    localparam int unsigned CFG_DATA_W  = 29;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CREDIT_W    = MIN_W + 1;

    localparam logic [63:0] PAGE_MASK = 64'(PAGE_BYTES - 1);

    localparam logic [MIN_W-1:0] MIN_WINDOW_RST  = MIN_W'(65536);
    localparam logic [MAX_W-1:0] MAX_WINDOW_RST  = MAX_W'(1048576);
    localparam logic [REQ_W-1:0] REQUEST_MAX_RST = REQ_W'(262144);

    // register indexes on the config port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_WINDOW  = 2'd0,
        REG_MAX_WINDOW  = 2'd1,
        REG_REQUEST_MAX = 2'd2
    } srp_reg_t;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_RANGE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] read_offset;
        logic [63:0] read_length;
        logic [63:0] file_end;
        logic [63:0] useful_credit;
        logic        memory_pressure;
        logic [63:0] query_generation;
        logic [24:0] query_length;
    } srp_item_t;

    typedef struct packed {
        logic        status;
        logic [63:0] proposal_generation;
        logic [62:0] proposal_offset;
        logic [24:0] proposal_length;
        logic        is_current;
    } srp_result_t;

    // item-only values worked out one stage ahead of the stream state
    typedef struct packed {
        logic                is_query;
        logic                range_bad;
        logic                drop;
        logic [63:0]         read_offset;
        logic [63:0]         read_end;
        logic [63:0]         first_page;
        logic [63:0]         file_end;
        logic [63:0]         file_end_up;
        logic [CREDIT_W-1:0] credit;
        logic [63:0]         query_generation;
        logic                query_len_nz;
    } srp_prep_t;

    function automatic logic [63:0] page_up(input logic [63:0] x);
        page_up = (x + PAGE_MASK) & ~PAGE_MASK;
    endfunction

endpackage

/* design/sequential_readahead_planner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_readahead_planner_unit: sequential readahead window planner
// An item beat moves through the item, prep and result registers in that order.
// Throughput: one item per cycle while result_stall is low.
// Stall on item rises only when all three stages hold beats and result stalls.
// Reset: rst_n async low; stream idle, generation zero, registers at defaults.
// ----------------------------------------------------------------------------
module sequential_readahead_planner_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [srp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  srp_pkg::srp_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output srp_pkg::srp_result_t                result
);

    // ------------------------------------------------------------------
    // Pipeline: item register -> prep register -> result register.
    // Prep holds everything that depends only on the item (range check,
    // end of read, page rounding, clipped credit). The last stage reads
    // and writes the stream state, so consecutive items see each
    // other's updates with no hazard.
    // ------------------------------------------------------------------

    // configuration
    logic [srp_pkg::MIN_W-1:0] min_window_reg;
    logic [srp_pkg::MAX_W-1:0] max_window_reg;
    logic [srp_pkg::REQ_W-1:0] request_max_reg;

    // stream state
    logic                      stream_valid_reg,     stream_valid_next;
    logic                      stream_exhausted_reg, stream_exhausted_next;
    logic [63:0]               generation_reg,       generation_next;
    logic [srp_pkg::MAX_W-1:0] window_reg,           window_next;
    logic [srp_pkg::MIN_W-1:0] useful_reg,           useful_next;
    logic [63:0]               expected_reg,         expected_next;
    logic [63:0]               issued_reg,           issued_next;

    // pipeline registers
    logic                 in_valid_reg;
    srp_pkg::srp_item_t   item_reg;
    logic                 prep_valid_reg;
    srp_pkg::srp_prep_t   prep_reg;
    srp_pkg::srp_prep_t   prep_next;
    logic                 out_valid_reg;
    srp_pkg::srp_result_t result_reg;
    srp_pkg::srp_result_t result_next;

    // flow control: each stage moves when the one after it has room
    logic out_free;
    logic prep_free;
    logic in_free;
    logic state_en;

    assign out_free   = !out_valid_reg || !result_stall;
    assign prep_free  = !prep_valid_reg || out_free;
    assign in_free    = !in_valid_reg || prep_free;
    assign state_en   = prep_valid_reg && out_free;
    assign item_stall = !in_free;

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Item-only precompute. A read is bad when eof is past 2^63-1 or
    // offset+length (65 bits, so no wrap) passes eof; offset beyond eof
    // is covered by the same compare.
    // ------------------------------------------------------------------
    logic [64:0] end_wide;

    always_comb
    begin
        end_wide = {1'b0, item_reg.read_offset} + {1'b0, item_reg.read_length};

        prep_next.is_query    = (item_reg.operation == srp_pkg::OP_QUERY);
        prep_next.range_bad   = item_reg.file_end[63] || (end_wide > {1'b0, item_reg.file_end});
        prep_next.drop        = item_reg.memory_pressure || (item_reg.read_length == 64'd0);
        prep_next.read_offset = item_reg.read_offset;
        prep_next.read_end    = end_wide[63:0];
        // three-operand add: round offset+length up to a page in one pass
        prep_next.first_page  = (item_reg.read_offset + item_reg.read_length
                                 + srp_pkg::PAGE_MASK) & ~srp_pkg::PAGE_MASK;
        prep_next.file_end    = item_reg.file_end;
        prep_next.file_end_up = srp_pkg::page_up(item_reg.file_end);
        // credit at or above 2^25 always exceeds the room left
        prep_next.credit      = (|item_reg.useful_credit[63:srp_pkg::MIN_W])
                                ? {1'b1, {srp_pkg::MIN_W{1'b0}}}
                                : {1'b0, item_reg.useful_credit[srp_pkg::MIN_W-1:0]};
        prep_next.query_generation = item_reg.query_generation;
        prep_next.query_len_nz     = (item_reg.query_length != '0);
    end

    // ------------------------------------------------------------------
    // Stream stage
    // ------------------------------------------------------------------
    logic                      gen_at_max;
    logic [63:0]               gen_bumped;
    logic                      seq_break;
    logic [srp_pkg::MIN_W+1:0] useful_sum;
    logic                      window_switch;
    logic [srp_pkg::MAX_W-1:0] window_cont;
    logic [63:0]               limit_raw;
    logic [63:0]               limit;
    logic [63:0]               first;
    logic [63:0]               span;
    logic [srp_pkg::MAX_W-1:0] avail;
    logic [srp_pkg::REQ_W-1:0] avail_cap;
    logic                      no_room;
    logic                      too_short;
    logic                      propose;

    always_comb
    begin
        gen_at_max = (generation_reg == '1);
        gen_bumped = generation_reg + 64'd1;
        seq_break  = stream_valid_reg && (prep_reg.read_offset != expected_reg);

        // useful credit saturates at min_window; hitting it opens the window
        useful_sum    = {2'b00, useful_reg} + {1'b0, prep_reg.credit};
        window_switch = (useful_reg <= min_window_reg)
                        && (useful_sum >= {2'b00, min_window_reg});
        window_cont   = window_switch ? max_window_reg : window_reg;

        limit_raw = prep_reg.first_page + {{(64-srp_pkg::MAX_W){1'b0}}, window_cont};
        limit     = (limit_raw > prep_reg.file_end_up) ? prep_reg.file_end_up : limit_raw;
        first     = (prep_reg.first_page < issued_reg) ? issued_reg : prep_reg.first_page;
        no_room   = (first >= limit) || (first >= prep_reg.file_end);
        // window is the upper bound on limit-first
        span      = limit - first;
        avail     = span[srp_pkg::MAX_W-1:0];
        too_short = (avail < {{(srp_pkg::MAX_W-srp_pkg::MIN_W+1){1'b0}},
                              min_window_reg[srp_pkg::MIN_W-1:1]})
                    && (limit != prep_reg.file_end_up);
        avail_cap = (avail > {{(srp_pkg::MAX_W-srp_pkg::REQ_W){1'b0}}, request_max_reg})
                    ? request_max_reg : avail[srp_pkg::REQ_W-1:0];
        propose   = !no_room && !too_short && (avail_cap != '0);

        stream_valid_next     = stream_valid_reg;
        stream_exhausted_next = stream_exhausted_reg;
        generation_next       = generation_reg;
        window_next           = window_reg;
        useful_next           = useful_reg;
        expected_next         = expected_reg;
        issued_next           = issued_reg;

        result_next.status              = srp_pkg::ST_OK;
        result_next.proposal_generation = '0;
        result_next.proposal_offset     = '0;
        result_next.proposal_length     = '0;
        result_next.is_current          = 1'b0;

        if (prep_reg.is_query)
        begin
            result_next.is_current = stream_valid_reg && !stream_exhausted_reg
                                     && prep_reg.query_len_nz
                                     && (prep_reg.query_generation == generation_reg);
        end
        else if (prep_reg.range_bad || prep_reg.drop || (!stream_exhausted_reg && seq_break))
        begin
            // stream reset; a bad range also flags the beat
            if (prep_reg.range_bad)
            begin
                result_next.status = srp_pkg::ST_BAD_RANGE;
            end
            stream_valid_next = 1'b0;
            window_next       = '0;
            useful_next       = '0;
            expected_next     = '0;
            issued_next       = '0;
            if (gen_at_max)
            begin
                stream_exhausted_next = 1'b1;
            end
            else
            begin
                generation_next = gen_bumped;
            end
            // a sequence break restarts right away on the new generation
            if (!prep_reg.range_bad && !prep_reg.drop && !gen_at_max)
            begin
                stream_valid_next = 1'b1;
                expected_next     = prep_reg.read_end;
                issued_next       = prep_reg.read_end;
                window_next       = {{(srp_pkg::MAX_W-srp_pkg::MIN_W){1'b0}}, min_window_reg};
            end
        end
        else if (stream_exhausted_reg)
        begin
            // dead stream: nothing moves
        end
        else if (!stream_valid_reg)
        begin
            // first read of a fresh stream; generation zero is never handed out
            if (generation_reg == '0)
            begin
                generation_next = 64'd1;
            end
            stream_valid_next = 1'b1;
            expected_next     = prep_reg.read_end;
            issued_next       = prep_reg.read_end;
            useful_next       = '0;
            window_next       = {{(srp_pkg::MAX_W-srp_pkg::MIN_W){1'b0}}, min_window_reg};
        end
        else
        begin
            expected_next = prep_reg.read_end;
            if (window_switch)
            begin
                useful_next = min_window_reg;
                window_next = max_window_reg;
            end
            else if (useful_reg <= min_window_reg)
            begin
                useful_next = useful_sum[srp_pkg::MIN_W-1:0];
            end
            if (propose)
            begin
                result_next.proposal_generation = generation_reg;
                result_next.proposal_offset     = first[62:0];
                result_next.proposal_length     = avail_cap;
                issued_next = first + {{(64-srp_pkg::REQ_W){1'b0}}, avail_cap};
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_window_reg       <= srp_pkg::MIN_WINDOW_RST;
            max_window_reg       <= srp_pkg::MAX_WINDOW_RST;
            request_max_reg      <= srp_pkg::REQUEST_MAX_RST;
            stream_valid_reg     <= 1'b0;
            stream_exhausted_reg <= 1'b0;
            generation_reg       <= '0;
            window_reg           <= '0;
            useful_reg           <= '0;
            expected_reg         <= '0;
            issued_reg           <= '0;
            in_valid_reg         <= 1'b0;
            prep_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    srp_pkg::REG_MIN_WINDOW:  min_window_reg  <= cfg_data[srp_pkg::MIN_W-1:0];
                    srp_pkg::REG_MAX_WINDOW:  max_window_reg  <= cfg_data[srp_pkg::MAX_W-1:0];
                    srp_pkg::REG_REQUEST_MAX: request_max_reg <= cfg_data[srp_pkg::REQ_W-1:0];
                    default: ;
                endcase
            end
            if (in_free)
            begin
                in_valid_reg <= item_valid;
            end
            if (prep_free)
            begin
                prep_valid_reg <= in_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= prep_valid_reg;
            end
            if (state_en)
            begin
                stream_valid_reg     <= stream_valid_next;
                stream_exhausted_reg <= stream_exhausted_next;
                generation_reg       <= generation_next;
                window_reg           <= window_next;
                useful_reg           <= useful_next;
                expected_reg         <= expected_next;
                issued_reg           <= issued_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_free)
        begin
            item_reg <= item;
        end
        if (prep_free)
        begin
            prep_reg <= prep_next;
        end
        if (out_free)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* design/srp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_checker: port-level checks of the readahead planner
// Watches both channels and the shape of result beats.
// ----------------------------------------------------------------------------
module srp_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input srp_pkg::srp_result_t result
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // a stalled item beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid)
        else $error("item beat withdrawn while stalled");

    // items back up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled with output free");

    // a proposal carries a live generation and is no query answer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.proposal_length != '0) |->
            (result.proposal_generation != '0)
            && (result.status == srp_pkg::ST_OK) && !result.is_current)
        else $error("malformed proposal beat");

endmodule

bind sequential_readahead_planner_unit srp_checker u_srp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
